// File: rtl/ssc_pkg.sv
//------------------------------------------------------------------------------
// ssc_pkg
// Shared codes, widths and controller/datapath interface types for the
// sleep stage classifier.
//------------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int ValW    = 16;
  localparam int FactorW = 12;
  localparam int NightW  = 8;
  localparam int StageW  = 2;
  localparam int CfgIdxW = 2;
  localparam int ProdW   = ValW + FactorW;
  localparam int SumW    = ValW + NightW + 1;
  localparam int DsrW    = NightW + 1;
  localparam int CntW    = $clog2(SumW + 1);
  localparam int InDataW  = 48;
  localparam int OutDataW = 32;

  localparam logic [NightW-1:0] NIGHT_MAX = 8'd255;
  localparam logic [1:0]        HIST_LEN  = 2'd3;

  localparam logic [StageW-1:0] STAGE_AWAKE = 2'd0;
  localparam logic [StageW-1:0] STAGE_LIGHT = 2'd1;
  localparam logic [StageW-1:0] STAGE_DEEP  = 2'd2;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_SESSION = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_MOTION = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STILL  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FACTOR = 2'd2;

  typedef struct packed {
    logic latch;
    logic mul;
    logic classify;
    logic div_init;
    logic div_step;
    logic update;
    logic out_load;
  } ssc_cmd_t;

  typedef struct packed {
    logic session;
    logic median_zero;
    logic night_zero;
    logic div_last;
    logic out_free;
  } ssc_status_t;

endpackage

`default_nettype wire

// File: rtl/sleep_stage_classifier.sv
//------------------------------------------------------------------------------
// sleep_stage_classifier
// Labels ticks awake/light/deep with 3-tick majority smoothing and keeps a
// running-mean RMSSD baseline over nights.
//------------------------------------------------------------------------------
// One word is processed at a time. A classify tick steps through latch,
// multiply, classify and load; a session end steps through latch, multiply
// and load when the median is zero, adds an update before the load on the
// first night, and otherwise runs the 25-step restoring divider of the
// baseline mean between multiply and update.
// The output register lets a result wait while the next word is accepted.
// Config writes are always ready and should be issued while idle.
`default_nettype none

module sleep_stage_classifier (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // activity, rmssd, night_median
  input  wire logic [0:0]  s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // stage, baseline_out, nights_out, zero pad
  output logic [0:0]       m_axis_tuser   // stage_valid
);
  import ssc_pkg::*;

  ssc_cmd_t    cmd;
  ssc_status_t status;

  assign cfg_ready = 1'b1;

  ssc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ssc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_cmd    (s_axis_tuser[0]),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_flag  (m_axis_tuser[0]),
    .out_data  (m_axis_tdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word accepted while busy");

  a_stage_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("illegal stage code");

  a_session_stage: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[1:0] == STAGE_AWAKE)
    else $error("stage not zero on session result");

  a_baseline_nights: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[17:2] == 16'd0) == (m_axis_tdata[25:18] == 8'd0)))
    else $error("baseline and night count disagree");

endmodule

`default_nettype wire

// File: rtl/ssc_ctrl.sv
//------------------------------------------------------------------------------
// ssc_ctrl
// Sequencer: accepts one word, steps the datapath through classify or baseline
// update (nonzero median only), then hands the result to the output register.
//------------------------------------------------------------------------------
`default_nettype none

module ssc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ssc_pkg::ssc_status_t status,
  output ssc_pkg::ssc_cmd_t         cmd
);
  import ssc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CLASS, S_DIVI, S_DIV, S_UPDATE, S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.latch    = (state == S_IDLE) && in_valid;
    cmd.mul      = (state == S_MUL);
    cmd.classify = (state == S_CLASS);
    cmd.div_init = (state == S_DIVI);
    cmd.div_step = (state == S_DIV);
    cmd.update   = (state == S_UPDATE);
    cmd.out_load = (state == S_FINISH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_MUL;
        end
        S_MUL: begin
          if (!status.session)         state <= S_CLASS;
          else if (status.median_zero) state <= S_FINISH;
          else if (status.night_zero)  state <= S_UPDATE;
          else                         state <= S_DIVI;
        end
        S_CLASS:  state <= S_FINISH;
        S_DIVI:   state <= S_DIV;
        S_DIV: begin
          if (status.div_last) state <= S_UPDATE;
        end
        S_UPDATE: state <= S_FINISH;
        S_FINISH: begin
          if (status.out_free) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/ssc_datapath.sv
//------------------------------------------------------------------------------
// ssc_datapath
// Config registers, shared multiplier, label history and vote, restoring
// divider for the baseline mean, and the output register.
//------------------------------------------------------------------------------
`default_nettype none

module ssc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ssc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [ssc_pkg::ValW-1:0]      cfg_data,
  input  wire logic                          in_cmd,
  input  wire logic [ssc_pkg::InDataW-1:0]   in_data,
  input  wire ssc_pkg::ssc_cmd_t             cmd,
  output ssc_pkg::ssc_status_t               status,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_flag,
  output logic [ssc_pkg::OutDataW-1:0]       out_data
);
  import ssc_pkg::*;

  logic [ValW-1:0]    motion_thr, still_thr;
  logic [FactorW-1:0] factor;

  logic               r_cmd;
  logic [ValW-1:0]    r_act, r_rmssd, r_median;

  logic [ValW-1:0]    baseline;
  logic [NightW-1:0]  nights;
  logic [ProdW-1:0]   prod;

  logic [StageW-1:0]  hist [HIST_LEN];
  logic [1:0]         slot, fill;
  logic [StageW-1:0]  stage_r;

  logic [SumW-1:0]    dvd;
  logic [DsrW-1:0]    rem, dsr;
  logic [CntW-1:0]    cnt;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_thr <= 16'hFFFF;
      still_thr  <= '0;
      factor     <= 12'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOTION: motion_thr <= cfg_data;
        CFG_STILL:  still_thr  <= cfg_data;
        CFG_FACTOR: factor     <= cfg_data[FactorW-1:0];
        default: ;
      endcase
    end
  end

  // input latch and shared multiplier
  logic [FactorW-1:0] mul_op;
  assign mul_op = r_cmd ? {{(FactorW-NightW){1'b0}}, nights} : factor;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_cmd    <= in_cmd;
      r_act    <= in_data[15:0];
      r_rmssd  <= in_data[31:16];
      r_median <= in_data[47:32];
    end
    if (cmd.mul) prod <= baseline * mul_op;
  end

  // classify and vote
  logic [ValW-1:0]   scaled;
  logic [StageW-1:0] inst, vote;
  logic [StageW-1:0] h0, h1, h2;

  assign scaled = (prod[ProdW-1:ValW+8] != '0) ? 16'hFFFF : prod[ValW+7:8];

  always_comb begin
    if (r_act > motion_thr)
      inst = STAGE_AWAKE;
    else if (r_act < still_thr && baseline != '0 && r_rmssd > scaled)
      inst = STAGE_DEEP;
    else
      inst = STAGE_LIGHT;
    h0 = (slot == 2'd0) ? inst : hist[0];
    h1 = (slot == 2'd1) ? inst : hist[1];
    h2 = (slot == 2'd2) ? inst : hist[2];
    if (fill < HIST_LEN - 2'd1) vote = inst;
    else if (h0 == h1 || h0 == h2) vote = h0;
    else if (h1 == h2) vote = h1;
    else vote = inst;
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      hist[slot] <= inst;
      stage_r    <= vote;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
    end else if (cmd.classify) begin
      slot <= (slot == HIST_LEN - 2'd1) ? 2'd0 : slot + 2'd1;
      if (fill != HIST_LEN) fill <= fill + 2'd1;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DsrW:0] rem_sh, rem_diff;
  logic          ge;

  assign rem_sh   = {rem, dvd[SumW-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign ge       = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd <= {1'b0, prod[SumW-2:0]} + {{(SumW-ValW){1'b0}}, r_median};
      dsr <= {1'b0, nights} + 9'd1;
      rem <= '0;
      cnt <= CntW'(SumW);
    end else if (cmd.div_step) begin
      rem <= ge ? rem_diff[DsrW-1:0] : rem_sh[DsrW-1:0];
      dvd <= {dvd[SumW-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  // baseline state
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
      nights   <= '0;
    end else if (cmd.update) begin
      baseline <= (nights == '0) ? r_median : dvd[ValW-1:0];
      if (nights != NIGHT_MAX) nights <= nights + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_flag <= (r_cmd == CMD_TICK);
      out_data <= {6'd0, nights, baseline,
                   (r_cmd == CMD_TICK) ? stage_r : STAGE_AWAKE};
    end
  end

  always_comb begin
    status             = '0;
    status.session     = (r_cmd == CMD_SESSION);
    status.median_zero = (r_median == '0);
    status.night_zero  = (nights == '0);
    status.div_last    = (cnt == CntW'(1));
    status.out_free    = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// File: test/sleep_stage_classifier_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// sleep_stage_classifier_test
// Self-checking bench for the sleep stage classifier. A behavioral copy of the
// labeling, 3-tick majority smoothing and nightly baseline mean predicts every
// result word; the checker compares each output word field by field against
// the oldest prediction. Directed corners come first, then random traffic
// under several threshold/factor settings, output backpressure, a full drain
// pause, and a run that saturates the night count.
//------------------------------------------------------------------------------
module sleep_stage_classifier_test;
  import ssc_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic              valid;
    logic [StageW-1:0] stage;
    logic [ValW-1:0]   baseline;
    logic [NightW-1:0] nights;
  } stage_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // activity, rmssd, night_median
  logic [0:0]  s_axis_tuser = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // stage, baseline_out, nights_out, zero pad
  logic [0:0]  m_axis_tuser;        // stage_valid

  sleep_stage_classifier uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [ValW-1:0]    motion_thr = 16'hFFFF;
  logic [ValW-1:0]    still_thr = 16'h0000;
  logic [FactorW-1:0] factor = 12'd256;
  logic [ValW-1:0]    baseline = '0;
  logic [NightW-1:0]  nights = '0;
  logic [StageW-1:0]  labels [3];
  int                 slot = 0;
  int                 fill = 0;

  stage_result_t due_results [$];
  int mismatches = 0;
  int burst_left = 0;
  bit tx_gaps = 1'b1;
  int hold_asked = 0;

  function automatic logic [ValW-1:0] scaled_base();
    logic [ProdW-1:0] p;
    p = baseline * factor;
    p = p >> 8;
    return (p > 16'hFFFF) ? 16'hFFFF : p[ValW-1:0];
  endfunction

  function automatic logic [ValW-1:0] jitter(input logic [ValW-1:0] v);
    return v + 16'($urandom_range(0, 4)) - 16'd2;
  endfunction

  task automatic classify_or_fold(input logic cmd, input logic [ValW-1:0] act,
                                  input logic [ValW-1:0] rm, input logic [ValW-1:0] med);
    stage_result_t r;
    logic [StageW-1:0] lab;
    logic [31:0] sum;
    r = '0;
    if (cmd == CMD_TICK) begin
      if (act > motion_thr) begin
        lab = STAGE_AWAKE;
      end else if (act < still_thr && baseline != 0 && rm > scaled_base()) begin
        lab = STAGE_DEEP;
      end else begin
        lab = STAGE_LIGHT;
      end
      labels[slot] = lab;
      slot = (slot == 2) ? 0 : slot + 1;
      if (fill < 3) fill++;
      if (fill < 3) begin
        r.stage = lab;
      end else if (labels[0] == labels[1] || labels[0] == labels[2]) begin
        r.stage = labels[0];
      end else if (labels[1] == labels[2]) begin
        r.stage = labels[1];
      end else begin
        r.stage = lab;
      end
      r.valid = 1'b1;
    end else if (med != 0) begin
      if (nights == 0) begin
        baseline = med;
      end else begin
        sum = baseline * nights + med;
        baseline = 16'(sum / (nights + 1));
      end
      if (nights != NIGHT_MAX) nights++;
    end
    r.baseline = baseline;
    r.nights = nights;
    due_results.push_back(r);
  endtask

  task automatic send_word(input logic cmd, input logic [ValW-1:0] act,
                           input logic [ValW-1:0] rm, input logic [ValW-1:0] med);
    if (tx_gaps && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {med, rm, act};
    do @(posedge clk); while (!s_axis_tready);
    classify_or_fold(cmd, act, rm, med);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_random_word(input int session_pct);
    logic c;
    logic [ValW-1:0] a, r, m;
    c = ($urandom_range(0, 99) < session_pct) ? CMD_SESSION : CMD_TICK;
    case ($urandom_range(0, 5))
      0, 1: a = 16'($urandom);
      2: a = jitter(motion_thr);
      3: a = jitter(still_thr);
      4: a = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: a = 16'($urandom_range(0, 2000));
    endcase
    r = $urandom_range(0, 1) ? 16'($urandom) : jitter(scaled_base());
    m = ($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom);
    send_word(c, a, r, m);
  endtask

  // wait until every predicted word has come back, then let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MOTION: motion_thr = val;
      CFG_STILL:  still_thr = val;
      CFG_FACTOR: factor = val[FactorW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] mot, input logic [15:0] stl,
                            input logic [15:0] fac);
    write_reg(CFG_MOTION, mot);
    write_reg(CFG_STILL, stl);
    write_reg(CFG_FACTOR, fac);
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_corners();
    send_word(CMD_TICK, 16'h0000, 16'h0000, 16'h1234);
    send_word(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(CMD_SESSION, 16'hFFFF, 16'hFFFF, 16'h0000);   // zero median ignored
    send_word(CMD_SESSION, 16'h0000, 16'h0000, 16'd1000);   // first night
    settle();
    set_config(16'd1000, 16'd500, 16'd256);
    send_word(CMD_TICK, 16'd1001, 16'd0, 16'd0);            // awake
    send_word(CMD_TICK, 16'd1000, 16'd0, 16'd0);
    send_word(CMD_TICK, 16'd499, 16'd1001, 16'd0);          // deep, all labels differ
    send_word(CMD_TICK, 16'd499, 16'd1000, 16'd0);          // rmssd equal to scaled
    send_word(CMD_TICK, 16'd0, 16'hFFFF, 16'd0);
    send_word(CMD_SESSION, 16'd0, 16'd0, 16'd2001);         // running mean
    send_word(CMD_SESSION, 16'd0, 16'd0, 16'hFFFF);
    settle();
    set_config(16'd1000, 16'd500, 16'd0);
    send_word(CMD_TICK, 16'd0, 16'd1, 16'd0);
    send_word(CMD_TICK, 16'd0, 16'd0, 16'd0);
    settle();
    set_config(16'd0, 16'hFFFF, 16'hFFFF);                  // factor saturates
    send_word(CMD_TICK, 16'd0, 16'hFFFF, 16'd0);
    send_word(CMD_TICK, 16'd1, 16'hFFFF, 16'd0);
    send_word(CMD_TICK, 16'hFFFE, 16'hFFFF, 16'd0);
    settle();
    set_config(16'hFFFF, 16'hFFFF, 16'd1);
    send_word(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'd0);
    send_word(CMD_TICK, 16'hFFFE, 16'hFFFF, 16'd0);
    send_word(CMD_TICK, 16'hFFFE, 16'd0, 16'd0);
    settle();
  endtask

  task automatic test_random_settings();
    logic [15:0] a, b;
    for (int ph = 0; ph < 5; ph++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (ph)
        0: set_config(16'hFFFF, 16'h0000, 16'd256);
        1: set_config(16'h0000, 16'hFFFF, 16'h0000);
        2: set_config(16'hFFFF, 16'hFFFF, 16'h0FFF);
        default: set_config((a > b) ? a : b, (a > b) ? b : a, 16'($urandom_range(0, 1023)));
      endcase
      repeat (220) send_random_word(10);
      settle();
    end
  endtask

  task automatic test_output_backpressure();
    set_config(16'd40000, 16'd20000, 16'd300);
    tx_gaps = 1'b0;
    hold_asked++;
    repeat (60) send_random_word(15);
    tx_gaps = 1'b1;
    settle();
  endtask

  task automatic test_sender_pause();
    repeat (60) send_random_word(10);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (60) send_random_word(10);
    settle();
  endtask

  task automatic test_night_saturation();
    set_config(16'd30000, 16'd30000, 16'd200);
    for (int i = 0; i < 300; i++) begin
      send_word(CMD_SESSION, 16'($urandom), 16'($urandom),
                ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535)));
      if (i % 4 == 3) send_random_word(0);
    end
    repeat (40) send_random_word(10);
    settle();
  endtask

  // receiver: random duty that changes over time, plus one long hold on request
  int hold_served = 0;
  int hold_left = 0;
  int rx_duty = 100;
  logic [5:0] duty_timer = '0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_asked;
    end else begin
      duty_timer <= duty_timer + 1'b1;
      if (duty_timer == 0) begin
        case ($urandom_range(0, 3))
          0: rx_duty <= 100;
          1: rx_duty <= 80;
          2: rx_duty <= 50;
          default: rx_duty <= 15;
        endcase
      end
      m_axis_tready <= ($urandom_range(0, 99) < rx_duty);
    end
  end

  // checker
  always @(posedge clk) begin
    stage_result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.valid = m_axis_tuser[0];
      got.stage = m_axis_tdata[1:0];
      got.baseline = m_axis_tdata[17:2];
      got.nights = m_axis_tdata[25:18];
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: valid=%0d stage=%0d base=%0d nights=%0d",
                   got.valid, got.stage, got.baseline, got.nights);
      end else begin
        want = due_results.pop_front();
        if (got.valid != want.valid || got.stage != want.stage ||
            got.baseline != want.baseline || got.nights != want.nights ||
            m_axis_tdata[31:26] != 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d pad=%0h",
                     want.valid, want.stage, want.baseline, want.nights,
                     got.valid, got.stage, got.baseline, got.nights, m_axis_tdata[31:26]);
        end
      end
    end
  end

  // watchdog: cycles with work pending but no word moving on either side
  int stalled = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (!s_axis_tvalid && due_results.size() == 0)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("sleep_stage_classifier_test: errors");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_random_settings();
    test_output_backpressure();
    test_sender_pause();
    test_night_saturation();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("sleep_stage_classifier_test: clean");
    end else begin
      $display("sleep_stage_classifier_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ssc_pkg.sv
rtl/ssc_ctrl.sv
rtl/ssc_datapath.sv
rtl/sleep_stage_classifier.sv
test/sleep_stage_classifier_test.sv
